[src/tar_pkg.sv]
// Shared types, constants and codes for the threshold alert rule.
package tar_pkg;

  localparam int NUM_SCOPES  = 4;
  localparam int NUM_METRICS = 16;

  localparam int SCOPE_W  = 2;
  localparam int METRIC_W = 4;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W   = 32;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RULE_ENABLED   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIRECTION      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WATCHED_METRIC = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RULE_SCOPE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RAISE_LEVEL    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLEAR_LEVEL    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RAISE_HOLD_MS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLEAR_HOLD_MS  = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_PEND_RAISE = 4'b0010,
    PH_ACTIVE     = 4'b0100,
    PH_PEND_CLEAR = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    CAUSE_NONE        = 2'd0,
    CAUSE_RECOVERED   = 2'd1,
    CAUSE_SOURCE_LOST = 2'd2,
    CAUSE_CTX_ENDED   = 2'd3
  } cause_t;

  typedef struct packed {
    logic                     enabled;
    logic                     direction;
    logic [METRIC_W-1:0]      metric;
    logic [SCOPE_W-1:0]       scope;
    logic signed [DATA_W-1:0] raise_level;
    logic signed [DATA_W-1:0] clear_level;
    logic [DATA_W-1:0]        raise_hold_ms;
    logic [DATA_W-1:0]        clear_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [METRIC_W-1:0]      metric_id;
    logic                     sample_valid;
    logic signed [DATA_W-1:0] sample_value;
    logic [DATA_W-1:0]        time_ms;
    logic [SCOPE_W-1:0]       scope_id;
    logic                     scope_on;
  } item_t;

  typedef struct packed {
    logic                     raised;
    cause_t                   cause;
    logic [DATA_W-1:0]        incident;
    logic [DATA_W-1:0]        time_ms;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] threshold;
  } event_t;

endpackage

[src/tar_cfg.sv]
// Configuration register file of the threshold alert rule.
module tar_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tar_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [tar_pkg::DATA_W-1:0]   cfg_wdata,
  output tar_pkg::cfg_t                cfg
);
  import tar_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RULE_ENABLED:   cfg_nxt.enabled       = cfg_wdata[0];
        REG_DIRECTION:      cfg_nxt.direction     = cfg_wdata[0];
        REG_WATCHED_METRIC: cfg_nxt.metric        = cfg_wdata[METRIC_W-1:0];
        REG_RULE_SCOPE:     cfg_nxt.scope         = cfg_wdata[SCOPE_W-1:0];
        REG_RAISE_LEVEL:    cfg_nxt.raise_level   = cfg_wdata;
        REG_CLEAR_LEVEL:    cfg_nxt.clear_level   = cfg_wdata;
        REG_RAISE_HOLD_MS:  cfg_nxt.raise_hold_ms = cfg_wdata;
        REG_CLEAR_HOLD_MS:  cfg_nxt.clear_hold_ms = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/tar_core.sv]
// Rule state and one-pass evaluation of a registered input word.
module tar_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  tar_pkg::cfg_t   cfg,
  input  tar_pkg::item_t  item,
  output logic            ev_valid,
  output tar_pkg::event_t ev
);
  import tar_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [DATA_W-1:0]       start_r, start_nxt;
  logic signed [DATA_W-1:0] last_r, last_nxt;
  logic [DATA_W-1:0]       cur_inc_r, cur_inc_nxt;
  logic [DATA_W-1:0]       next_inc_r, next_inc_nxt;
  logic [NUM_SCOPES-1:0]   scope_act_r, scope_act_nxt;

  logic                    scope_ok, metric_hit, rs_active, has_inc;
  logic signed [DATA_W-1:0] v, rl, cl;
  logic                    want_raise, want_clear;
  logic [DATA_W-1:0]       elapsed, next_inc_inc;
  logic                    do_drop, do_raise, do_recover;
  cause_t                  drop_cause;

  assign scope_ok   = int'(item.scope_id) < NUM_SCOPES;
  assign metric_hit = (int'(item.metric_id) < NUM_METRICS) && (item.metric_id == cfg.metric);
  assign rs_active  = (int'(cfg.scope) < NUM_SCOPES) && scope_act_r[cfg.scope];
  assign has_inc    = (phase_r == PH_ACTIVE) || (phase_r == PH_PEND_CLEAR);

  assign v  = item.sample_value;
  assign rl = cfg.raise_level;
  assign cl = cfg.clear_level;
  assign want_raise = cfg.direction ? (v <= rl) : (v >= rl);
  assign want_clear = cfg.direction ? (v >= cl) : (v <= cl);
  assign elapsed      = item.time_ms - start_r;
  assign next_inc_inc = next_inc_r + 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    last_nxt      = last_r;
    cur_inc_nxt   = cur_inc_r;
    next_inc_nxt  = next_inc_r;
    scope_act_nxt = scope_act_r;
    do_drop       = 1'b0;
    do_raise      = 1'b0;
    do_recover    = 1'b0;
    drop_cause    = CAUSE_NONE;
    ev_valid      = 1'b0;
    ev.raised     = 1'b0;
    ev.cause      = CAUSE_NONE;
    ev.incident   = cur_inc_r;
    ev.time_ms    = item.time_ms;
    ev.value      = last_r;
    ev.threshold  = cfg.raise_level;

    if (fire) begin
      if (item.kind) begin
        if (scope_ok && (scope_act_r[item.scope_id] != item.scope_on)) begin
          scope_act_nxt[item.scope_id] = item.scope_on;
          if (!item.scope_on && (cfg.scope == item.scope_id)) begin
            do_drop    = 1'b1;
            drop_cause = CAUSE_CTX_ENDED;
          end
        end
      end else if (metric_hit && cfg.enabled) begin
        if (!rs_active) begin
          do_drop    = 1'b1;
          drop_cause = CAUSE_CTX_ENDED;
        end else if (!item.sample_valid) begin
          do_drop    = 1'b1;
          drop_cause = CAUSE_SOURCE_LOST;
        end else begin
          last_nxt = item.sample_value;
          case (phase_r)
            PH_IDLE: begin
              if (want_raise) begin
                phase_nxt = PH_PEND_RAISE;
                start_nxt = item.time_ms;
                do_raise  = (cfg.raise_hold_ms == '0);
              end
            end
            PH_PEND_RAISE: begin
              if (!want_raise) begin
                phase_nxt = PH_IDLE;
              end else begin
                do_raise = (elapsed >= cfg.raise_hold_ms);
              end
            end
            PH_ACTIVE: begin
              if (want_clear) begin
                phase_nxt  = PH_PEND_CLEAR;
                start_nxt  = item.time_ms;
                do_recover = (cfg.clear_hold_ms == '0);
              end
            end
            PH_PEND_CLEAR: begin
              if (!want_clear) begin
                phase_nxt = PH_ACTIVE;
              end else begin
                do_recover = (elapsed >= cfg.clear_hold_ms);
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end

      // drop to idle, ending any open incident
      if (do_drop) begin
        phase_nxt = PH_IDLE;
        if (has_inc) begin
          ev_valid    = 1'b1;
          ev.cause    = drop_cause;
          cur_inc_nxt = '0;
        end
      end

      if (do_raise) begin
        phase_nxt    = PH_ACTIVE;
        cur_inc_nxt  = next_inc_r;
        next_inc_nxt = (next_inc_inc == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : next_inc_inc;
        ev_valid     = 1'b1;
        ev.raised    = 1'b1;
        ev.incident  = next_inc_r;
        ev.value     = item.sample_value;
      end

      if (do_recover) begin
        phase_nxt   = PH_IDLE;
        cur_inc_nxt = '0;
        ev_valid    = 1'b1;
        ev.cause    = CAUSE_RECOVERED;
        ev.value    = item.sample_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      start_r    <= '0;
      last_r     <= '0;
      cur_inc_r  <= '0;
      next_inc_r <= {{(DATA_W-1){1'b0}}, 1'b1};
      for (int i = 0; i < NUM_SCOPES; i++) begin
        scope_act_r[i] <= (i == 0);
      end
    end else begin
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      cur_inc_r   <= cur_inc_nxt;
      next_inc_r  <= next_inc_nxt;
      scope_act_r <= scope_act_nxt;
    end
  end

endmodule

[src/threshold_alert_rule_top.sv]
// Top level of the threshold alert rule: input register, rule core, result register.
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_ready    kind, metric, sample, time, scope change
//   out_     out        out_valid / out_ready  raise or clear event (zero or one per word)
//   cfg_     in         cfg_we (no wait)       cfg_index, cfg_wdata
//
// A word waits in the input register, is evaluated there in a single pass against
// the rule state when it advances, and its event (if any) lands in the result
// register as the word leaves; one word per cycle sustained while the result
// register is not blocked.
// Reset (rst_n low, synchronous) empties both registers, clears configuration,
// puts the rule in idle with incident counter one and only scope zero active.
// A stalled result register holds the input register, which then drops in_ready.
module threshold_alert_rule_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [tar_pkg::METRIC_W-1:0]  in_metric_id,
  input  logic                          in_sample_valid,
  input  logic signed [tar_pkg::DATA_W-1:0] in_sample_value,
  input  logic [tar_pkg::DATA_W-1:0]    in_time_ms,
  input  logic [tar_pkg::SCOPE_W-1:0]   in_scope_id,
  input  logic                          in_scope_on,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_event_raised,
  output logic [1:0]                    out_clear_cause,
  output logic [tar_pkg::DATA_W-1:0]    out_incident_number,
  output logic [tar_pkg::DATA_W-1:0]    out_event_time_ms,
  output logic signed [tar_pkg::DATA_W-1:0] out_event_value,
  output logic signed [tar_pkg::DATA_W-1:0] out_event_threshold,
  // configuration port
  input  logic                          cfg_we,
  input  logic [tar_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [tar_pkg::DATA_W-1:0]    cfg_wdata
);
  import tar_pkg::*;

  cfg_t   cfg;
  item_t  s1_item_r, s1_item_nxt;
  logic   s1_valid_r, s1_valid_nxt;
  event_t out_ev_r, out_ev_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   adv;
  logic   ev_valid;
  event_t ev;

  tar_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the input word whenever the result register is free or being drained.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  tar_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (adv),
    .cfg      (cfg),
    .item     (s1_item_r),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  always_comb begin
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt              = 1'b1;
      s1_item_nxt.kind          = in_kind;
      s1_item_nxt.metric_id     = in_metric_id;
      s1_item_nxt.sample_valid  = in_sample_valid;
      s1_item_nxt.sample_value  = in_sample_value;
      s1_item_nxt.time_ms       = in_time_ms;
      s1_item_nxt.scope_id      = in_scope_id;
      s1_item_nxt.scope_on      = in_scope_on;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Load the result register on advance; drop it once taken.
  always_comb begin
    out_ev_nxt    = out_ev_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = ev_valid;
      if (ev_valid) begin
        out_ev_nxt = ev;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_ev_r  <= out_ev_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_event_raised    = out_ev_r.raised;
  assign out_clear_cause     = out_ev_r.cause;
  assign out_incident_number = out_ev_r.incident;
  assign out_event_time_ms   = out_ev_r.time_ms;
  assign out_event_value     = out_ev_r.value;
  assign out_event_threshold = out_ev_r.threshold;

  // Input side stalls only behind a full, blocked result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a blocked result register");

  // A raise never carries incident zero.
  a_raise_incident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_raised) |-> (out_incident_number != '0))
    else $error("raise event with incident number zero");

  // Raises carry no cause; clears always carry one.
  a_cause_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_raised == (out_clear_cause == CAUSE_NONE)))
    else $error("event kind and clear cause disagree");

  // A taken result with no new word behind it empties the result register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !s1_valid_r) |=> !out_valid)
    else $error("result word repeated");

endmodule
